// ===== hdl/avd_pkg.sv =====
// Shared constants and helpers for the adaptive vibration detector.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps

package avd_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int ACC_W     = 16;
    localparam int LEVEL_W   = 12;
    localparam int PAD_W     = 8;
    localparam int HOLD_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int SHIFT     = 4;

    localparam logic [ACC_W-1:0] DECAY_OFFSET   = 16'd8;
    localparam logic [ACC_W-1:0] BASELINE_RESET = 16'd8176;
    localparam logic [ACC_W-1:0] UPPER_RESET    = 16'd8320;
    localparam logic [ACC_W-1:0] LOWER_RESET    = 16'd8000;
    localparam logic [PAD_W-1:0] PAD_RESET      = 8'd16;
    localparam logic [HOLD_W-1:0] HOLD_RESET    = 16'd200;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_PADDING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS    = 1'b1;

    // One EWMA step, weight 1/16, accumulator kept 16x scaled, wraps mod 2^16
    function automatic logic [ACC_W-1:0] ewma_step(
        input logic [ACC_W-1:0]    acc,
        input logic [SAMPLE_W-1:0] s
    );
        logic [ACC_W-1:0] decay;
        decay = (acc - DECAY_OFFSET) >> SHIFT;
        return ACC_W'(s) + acc - decay;
    endfunction

endpackage

// ===== hdl/avd_if.sv =====
// Valid/ready channel interfaces for the sample and result streams.
// Depends on avd_pkg for field widths.
`timescale 1ns / 1ps

interface avd_sample_if;
    import avd_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface avd_result_if;
    import avd_pkg::*;

    logic               valid;
    logic               ready;
    logic               below_hit;
    logic               above_hit;
    logic               switch_on;
    logic [LEVEL_W-1:0] baseline_level;
    logic [LEVEL_W-1:0] low_envelope;
    logic [LEVEL_W-1:0] high_envelope;

    modport source (output valid, output below_hit, output above_hit, output switch_on,
                    output baseline_level, output low_envelope, output high_envelope,
                    input ready);
    modport sink   (input valid, input below_hit, input above_hit, input switch_on,
                    input baseline_level, input low_envelope, input high_envelope,
                    output ready);
endinterface

// ===== hdl/adaptive_vibration_detector_core.sv =====
// Adaptive vibration detector: EWMA baseline, noise envelopes, hold timer.
// Depends on avd_pkg and the channel interfaces in avd_if.sv.
`timescale 1ns / 1ps

// Usage
//   samples : valid/ready sink, one 10-bit converter reading per transfer.
//   results : valid/ready source, one result per sample, in order: the
//             below/above flags, the held switch and the three levels
//             (accumulators >> 4) after the update.
//   cfg_*   : write-only port. cfg_index 0 = noise_padding (8 bits),
//             1 = hold_ticks (16 bits); written on any edge with cfg_we
//             high. Write only while no sample is in flight.
// Timing
//   Two stages: an input register, then the detector logic feeding the
//   result register. A sample moves from the input register into the
//   result register once the result register is free; one sample per
//   cycle is sustained while results.ready stays high, set by the single
//   pass through the accumulator update and threshold compare.
// Reset (rst_n low, async)
//   Accumulators return to baseline 8176, upper 8320, lower 8000; the
//   hold timer clears and the switch goes off; registers go to 16/200.
// Backpressure
//   While a result waits with results.ready low the result register holds;
//   an empty input register still takes one more sample, then samples.ready drops.

module adaptive_vibration_detector_core (
    input  logic                             clk,
    input  logic                             rst_n,
    avd_sample_if.sink                       samples,
    avd_result_if.source                     results,
    input  logic                             cfg_we,
    input  logic [avd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [avd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import avd_pkg::*;

    // Configuration registers
    logic [PAD_W-1:0]  noise_padding_reg;
    logic [HOLD_W-1:0] hold_ticks_reg;

    // Input stage
    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;

    // Detector state
    logic [ACC_W-1:0]  baseline_reg, baseline_next;
    logic [ACC_W-1:0]  upper_reg, upper_next;
    logic [ACC_W-1:0]  lower_reg, lower_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic              switch_reg, switch_next;

    // Result stage
    logic               out_valid_reg;
    logic               below_reg, below_next;
    logic               above_reg, above_next;

    logic               advance;
    logic               fire;
    logic [ACC_W-1:0]   mid;
    logic [ACC_W-1:0]   thr;
    logic [ACC_W-1:0]   lo_lim;
    logic [ACC_W-1:0]   hi_lim;
    logic [ACC_W-1:0]   s_ext;

    // Result register frees up when empty or being drained this cycle
    assign advance       = !out_valid_reg || results.ready;
    assign fire          = s1_valid_reg && advance;
    assign samples.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_padding_reg <= PAD_RESET;
            hold_ticks_reg    <= HOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NOISE_PADDING: noise_padding_reg <= cfg_data[PAD_W-1:0];
                CFG_HOLD_TICKS:    hold_ticks_reg    <= cfg_data[HOLD_W-1:0];
                default:           ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            s1_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            s1_sample_reg <= samples.sample;
        end
    end

    // Detector pass: baseline first, then envelopes against the new midpoint
    always_comb
    begin
        s_ext         = ACC_W'(s1_sample_reg);
        baseline_next = ewma_step(baseline_reg, s1_sample_reg);
        mid           = baseline_next >> SHIFT;
        upper_next    = (s_ext > mid) ? ewma_step(upper_reg, s1_sample_reg) : upper_reg;
        lower_next    = (s_ext < mid) ? ewma_step(lower_reg, s1_sample_reg) : lower_reg;

        // Wrapping 16-bit threshold and limits, no saturation
        thr    = upper_next - lower_next + ACC_W'(noise_padding_reg);
        lo_lim = (baseline_next - thr) >> SHIFT;
        hi_lim = (baseline_next + thr) >> SHIFT;

        // Below test has priority when both limits are crossed
        below_next = (s_ext < lo_lim);
        above_next = !below_next && (s_ext > hi_lim);

        hold_next   = hold_reg;
        switch_next = switch_reg;
        if (below_next || above_next)
        begin
            switch_next = 1'b1;
            hold_next   = hold_ticks_reg;
        end
        else if (hold_reg != '0)
        begin
            hold_next = hold_reg - HOLD_W'(1);
        end
        else
        begin
            switch_next = 1'b0;
        end
    end

    // State updates only on fire; result valid updates whenever advance is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg  <= BASELINE_RESET;
            upper_reg     <= UPPER_RESET;
            lower_reg     <= LOWER_RESET;
            hold_reg      <= '0;
            switch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                baseline_reg <= baseline_next;
                upper_reg    <= upper_next;
                lower_reg    <= lower_next;
                hold_reg     <= hold_next;
                switch_reg   <= switch_next;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            below_reg <= below_next;
            above_reg <= above_next;
        end
    end

    // Levels and switch come straight off the state registers, which only
    // change together with the result register
    assign results.valid          = out_valid_reg;
    assign results.below_hit      = below_reg;
    assign results.above_hit      = above_reg;
    assign results.switch_on      = switch_reg;
    assign results.baseline_level = baseline_reg[ACC_W-1:SHIFT];
    assign results.low_envelope   = lower_reg[ACC_W-1:SHIFT];
    assign results.high_envelope  = upper_reg[ACC_W-1:SHIFT];

endmodule

// ===== verif/avd_scoreboard_pkg.sv =====
// Scoreboard for the adaptive vibration detector: predicts each result and checks it.
// Depends on avd_pkg for widths, reset values and register defaults.
`timescale 1ns / 1ps

package avd_scoreboard_pkg;
    import avd_pkg::*;

    typedef struct packed {
        logic               below_hit;
        logic               above_hit;
        logic               switch_on;
        logic [LEVEL_W-1:0] baseline_level;
        logic [LEVEL_W-1:0] low_envelope;
        logic [LEVEL_W-1:0] high_envelope;
    } detection_t;

    class detection_scoreboard;
        logic [PAD_W-1:0]  padding;
        logic [HOLD_W-1:0] hold_reload;
        logic [ACC_W-1:0]  baseline;
        logic [ACC_W-1:0]  upper_env;
        logic [ACC_W-1:0]  lower_env;
        logic [HOLD_W-1:0] hold_left;
        logic              sw_on;
        detection_t        awaited[$];
        int unsigned       failures;
        int unsigned       checked;
        int unsigned       below_count;
        int unsigned       above_count;
        int unsigned       both_count;
        int unsigned       releases;

        function new();
            padding     = PAD_RESET;
            hold_reload = HOLD_RESET;
            baseline    = BASELINE_RESET;
            upper_env   = UPPER_RESET;
            lower_env   = LOWER_RESET;
            hold_left   = '0;
            sw_on       = 1'b0;
            failures    = 0;
            checked     = 0;
            below_count = 0;
            above_count = 0;
            both_count  = 0;
            releases    = 0;
        endfunction

        function void adopt_settings(logic [PAD_W-1:0] pad, logic [HOLD_W-1:0] hold);
            padding     = pad;
            hold_reload = hold;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // 1/16-weight average on a 16x-scaled accumulator, mod 2^16
        function logic [ACC_W-1:0] smooth(logic [ACC_W-1:0] acc, logic [SAMPLE_W-1:0] s);
            logic [ACC_W-1:0] leak;
            logic [ACC_W-1:0] s_wide;
            s_wide = {{(ACC_W-SAMPLE_W){1'b0}}, s};
            leak   = acc - DECAY_OFFSET;
            leak   = leak >> SHIFT;
            return acc + s_wide - leak;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s);
            logic [ACC_W-1:0] s_wide;
            logic [ACC_W-1:0] mid;
            logic [ACC_W-1:0] spread;
            logic [ACC_W-1:0] lo_sum;
            logic [ACC_W-1:0] hi_sum;
            logic             over_top;
            detection_t       d;
            s_wide   = {{(ACC_W-SAMPLE_W){1'b0}}, s};
            baseline = smooth(baseline, s);
            mid      = baseline >> SHIFT;
            if (s_wide > mid)
                upper_env = smooth(upper_env, s);
            if (s_wide < mid)
                lower_env = smooth(lower_env, s);
            spread   = upper_env - lower_env + {{(ACC_W-PAD_W){1'b0}}, padding};
            lo_sum   = baseline - spread;
            hi_sum   = baseline + spread;
            over_top = s_wide > (hi_sum >> SHIFT);
            // lower limit wins when both are crossed
            d.below_hit = s_wide < (lo_sum >> SHIFT);
            d.above_hit = !d.below_hit && over_top;
            if (d.below_hit)
                below_count++;
            if (d.above_hit)
                above_count++;
            if (d.below_hit && over_top)
                both_count++;
            if (d.below_hit || d.above_hit)
            begin
                sw_on     = 1'b1;
                hold_left = hold_reload;
            end
            else if (hold_left != '0)
                hold_left = hold_left - HOLD_W'(1);
            else
            begin
                if (sw_on)
                    releases++;
                sw_on = 1'b0;
            end
            d.switch_on      = sw_on;
            d.baseline_level = baseline[ACC_W-1:SHIFT];
            d.low_envelope   = lower_env[ACC_W-1:SHIFT];
            d.high_envelope  = upper_env[ACC_W-1:SHIFT];
            awaited.push_back(d);
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                failures++;
            end
        endfunction

        function void check_result(detection_t got);
            detection_t want;
            if (awaited.size() == 0)
            begin
                $error("result transfer with no sample outstanding");
                failures++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            compare("below_hit", want.below_hit, got.below_hit);
            compare("above_hit", want.above_hit, got.above_hit);
            compare("switch_on", want.switch_on, got.switch_on);
            compare("baseline_level", want.baseline_level, got.baseline_level);
            compare("low_envelope", want.low_envelope, got.low_envelope);
            compare("high_envelope", want.high_envelope, got.high_envelope);
        endfunction
    endclass

endpackage

// ===== verif/tb_adaptive_vibration_detector_core.sv =====
// Self-checking testbench for adaptive_vibration_detector_core.
// Depends on avd_pkg, the channel interfaces in avd_if.sv and avd_scoreboard_pkg.
`timescale 1ns / 1ps

module tb_adaptive_vibration_detector_core;
    import avd_pkg::*;
    import avd_scoreboard_pkg::*;

    // Watchdog limit, set well above the length of a correct run.
    localparam int CYCLE_LIMIT   = 400000;
    // Idle time after the last result has been checked.
    localparam int SETTLE_CYCLES = 6;

    // Directed openers at reset settings: rails, alternating bit patterns,
    // the sketch's nominal mid-scale values, then a spike each way.
    localparam logic [SAMPLE_W-1:0] OPENERS[12] = '{
        10'd0, 10'd1023, 10'h2AA, 10'h155, 10'd511, 10'd511,
        10'd520, 10'd500, 10'd1023, 10'd0, 10'd1, 10'd512
    };
    // Run with zero hold and no padding: a hit turns the switch on for that
    // sample only; the next quiet sample finds the timer at zero and drops it.
    localparam logic [SAMPLE_W-1:0] ZERO_HOLD_RUN[9] = '{
        10'd511, 10'd511, 10'd511, 10'd1023, 10'd511, 10'd511, 10'd0, 10'd511, 10'd511
    };

    typedef enum {MIX_NOISE, MIX_QUIET, MIX_DITHER, MIX_STEP, MIX_RAIL} mix_kind_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    avd_sample_if sample_ch();
    avd_result_if result_ch();

    detection_scoreboard detections;

    int   idle_pct;       // chance per item that the sender leaves a gap
    int   stall_pct;      // chance per cycle that the receiver drops ready
    int   settings_count;
    int   cycle_count;
    int   hold_len;
    logic hold_active;    // long receiver hold-off in progress
    event start_hold;

    adaptive_vibration_detector_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .results   (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: any hang ends the run as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: check every transfer against the oldest prediction, then
    // pick ready for the next edge. Values read right after the edge are the
    // pre-edge ones, so the handshake is sampled cleanly.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                detections.check_result({result_ch.below_hit, result_ch.above_hit,
                                         result_ch.switch_on, result_ch.baseline_level,
                                         result_ch.low_envelope, result_ch.high_envelope});
            result_ch.ready <= hold_active ? 1'b0 : ($urandom_range(99) >= stall_pct);
        end
    end

    // Long receiver hold-off, counted here so the sender keeps offering
    // samples meanwhile and the input side fills and backs up.
    initial
    begin
        hold_active = 1'b0;
        forever
        begin
            @(start_hold);
            @(posedge clk);
            hold_active <= 1'b1;
            repeat (hold_len) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    // One sample transfer. A gap, if rolled, drops valid before the sample
    // is offered; otherwise valid stays high straight into the next sample.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        if ($urandom_range(99) < idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        detections.note_sample(s);
    endtask

    // Wait for every predicted result, then let the pipe go quiet.
    task automatic wait_idle();
        while (detections.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Both registers, back to back; junk in the unused upper byte of the
    // padding write must be ignored.
    task automatic write_settings(input logic [PAD_W-1:0] pad, input logic [HOLD_W-1:0] hold);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NOISE_PADDING;
        cfg_data  <= {(CFG_DATA_W-PAD_W)'($urandom), pad};
        @(posedge clk);
        cfg_index <= CFG_HOLD_TICKS;
        cfg_data  <= hold;
        @(posedge clk);
        cfg_we <= 1'b0;
        detections.adopt_settings(pad, hold);
        settings_count++;
    endtask

    // Random stimulus built from short scenes:
    //   noise  - uniform samples, every bit toggles
    //   quiet  - steady level with small jitter and rare spikes; the hold
    //            timer runs down and the switch releases
    //   dither - floor-level 0/small alternation that drags baseline and
    //            envelopes to the bottom, then a spike; with the spread larger
    //            than the baseline the lower limit wraps and both limits trip
    //   step   - one level, then its mirror
    //   rail   - 0/1023 bursts
    task automatic play_mix(input int items);
        int        left;
        int        len;
        int        level;
        int        amp;
        int        tip;
        int        v;
        int        pick;
        mix_kind_t kind;
        left = items;
        while (left > 0)
        begin
            pick = $urandom_range(9);
            if (pick < 2)
                kind = MIX_NOISE;
            else if (pick < 6)
                kind = MIX_QUIET;
            else if (pick < 8)
                kind = MIX_DITHER;
            else if (pick < 9)
                kind = MIX_STEP;
            else
                kind = MIX_RAIL;
            case (kind)
                MIX_NOISE:  len = $urandom_range(1, 20);
                MIX_QUIET:  len = $urandom_range(10, 60);
                MIX_DITHER: len = $urandom_range(40, 120);
                MIX_STEP:   len = $urandom_range(10, 40);
                default:    len = $urandom_range(2, 8);
            endcase
            if (len > left)
                len = left;
            level = $urandom_range(1023);
            amp   = $urandom_range(6);
            tip   = $urandom_range(1, 5);
            for (int k = 0; k < len; k++)
            begin
                case (kind)
                    MIX_NOISE:
                        v = $urandom_range(1023);
                    MIX_QUIET:
                        if ($urandom_range(14) == 0)
                            v = $urandom_range(1) ? 1023 : 0;
                        else
                            v = level + int'($urandom_range(2 * amp)) - amp;
                    MIX_DITHER:
                        if (k == len - 1)
                            v = $urandom_range(512, 1023);
                        else
                            v = (k % 2 == 1) ? tip : 0;
                    MIX_STEP:
                        v = (k < len / 2) ? level : 1023 - level;
                    default:
                        v = $urandom_range(1) ? 1023 : 0;
                endcase
                if (v < 0)
                    v = 0;
                if (v > 1023)
                    v = 1023;
                send_sample(SAMPLE_W'(v));
            end
            left -= len;
        end
    endtask

    // One phase: drain (sender pauses until all results are in), new
    // settings, idle profile, optional long hold-off, then the random mix.
    task automatic run_phase(input logic [PAD_W-1:0] pad, input logic [HOLD_W-1:0] hold,
                             input int idle, input int stall, input int items,
                             input int stretch);
        wait_idle();
        write_settings(pad, hold);
        idle_pct  = idle;
        stall_pct = stall;
        if (stretch > 0)
        begin
            hold_len = stretch;
            -> start_hold;
        end
        play_mix(items);
        sample_ch.valid <= 1'b0;
    endtask

    initial
    begin
        detections       = new();
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_NOISE_PADDING;
        cfg_data         = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        idle_pct         = 0;
        stall_pct        = 0;
        settings_count   = 0;
        hold_len         = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings first, then zero hold with no padding.
        foreach (OPENERS[i])
            send_sample(OPENERS[i]);
        sample_ch.valid <= 1'b0;
        wait_idle();
        write_settings(8'd0, 16'd0);
        foreach (ZERO_HOLD_RUN[i])
            send_sample(ZERO_HOLD_RUN[i]);
        sample_ch.valid <= 1'b0;

        // Random phases across register extremes and idle profiles.
        run_phase(8'd0,   16'd0,     0,  0,  250, 0);
        run_phase(8'd255, 16'd65535, 76, 0,  250, 0);
        run_phase(8'd128, 16'd3,     0,  76, 250, 0);
        run_phase(8'd255, 16'd1,     10, 10, 300, 0);
        run_phase(8'd40,  16'd20,    0,  0,  200, 80);
        run_phase(8'd255, 16'd12,    0,  0,  300, 0);
        run_phase(8'd16,  16'd200,   10, 10, 300, 0);

        wait_idle();
        $display("Checked %0d results over %0d register settings and all idle profiles.",
                 detections.checked, settings_count);
        $display("Hits: %0d below, %0d above, %0d with both limits crossed; %0d releases.",
                 detections.below_count, detections.above_count,
                 detections.both_count, detections.releases);
        if (detections.failures == 0 && detections.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== adaptive_vibration_detector_core.f =====
hdl/avd_pkg.sv
hdl/avd_if.sv
hdl/adaptive_vibration_detector_core.sv
verif/avd_scoreboard_pkg.sv
verif/tb_adaptive_vibration_detector_core.sv
